// File: design/telnet_option_negotiator_top_defines.svh
// Assertion macros used by the checker file
`ifndef TELNET_OPTION_NEGOTIATOR_TOP_DEFINES_SVH
`define TELNET_OPTION_NEGOTIATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tn_neg_pkg.sv
`default_nettype none

package tn_neg_pkg;

    // Telnet command bytes
    localparam logic [7:0] B_IAC  = 8'hFF;
    localparam logic [7:0] B_DONT = 8'hFE;
    localparam logic [7:0] B_DO   = 8'hFD;
    localparam logic [7:0] B_WONT = 8'hFC;
    localparam logic [7:0] B_WILL = 8'hFB;
    localparam logic [7:0] B_SB   = 8'hFA;
    localparam logic [7:0] B_SE   = 8'hF0;

    // Option codes
    localparam logic [7:0] TN_ECHO  = 8'd1;
    localparam logic [7:0] TN_SGA   = 8'd3;
    localparam logic [7:0] TN_TTYPE = 8'd24;
    localparam logic [7:0] TN_NAWS  = 8'd31;
    localparam logic [7:0] TTYPE_SEND = 8'd1;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [7:0] WIDTH_RESET  = 8'd80;
    localparam logic [7:0] HEIGHT_RESET = 8'd24;

    // Pending verb codes
    typedef enum logic [1:0] {
        VERB_WILL = 2'd0,
        VERB_WONT = 2'd1,
        VERB_DO   = 2'd2,
        VERB_DONT = 2'd3
    } verb_t;

    // Kind of output burst caused by one received byte
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_REPLY3 = 2'd1,
        KIND_NAWS   = 2'd2,
        KIND_TTYPE  = 2'd3
    } kind_t;

    // One burst as handed from the parser to the emitter
    typedef struct packed {
        kind_t      kind;
        logic [7:0] verb;
        logic [7:0] data;
        logic       echo;
    } burst_t;

    // Number of bytes in a burst
    function automatic logic [3:0] burst_len(input kind_t kind);
        logic [3:0] len;
        case (kind)
            KIND_DATA:   len = 4'd1;
            KIND_REPLY3: len = 4'd3;
            KIND_NAWS:   len = 4'd12;
            KIND_TTYPE:  len = 4'd11;
            default:     len = 4'd1;
        endcase
        return len;
    endfunction

    // Terminal type answer: IAC SB TTYPE IS "vt220" IAC SE
    function automatic logic [7:0] ttype_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = B_IAC;
            4'd1:    b = B_SB;
            4'd2:    b = TN_TTYPE;
            4'd3:    b = 8'd0;
            4'd4:    b = 8'h76;
            4'd5:    b = 8'h74;
            4'd6:    b = 8'h32;
            4'd7:    b = 8'h32;
            4'd8:    b = 8'h30;
            4'd9:    b = B_IAC;
            default: b = B_SE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/tn_neg_parse.sv
`default_nettype none

module tn_neg_parse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    output tn_neg_pkg::burst_t     desc,
    output logic                   desc_valid
);
    import tn_neg_pkg::*;

    typedef enum logic [4:0] {
        PH_DATA   = 5'b00001,
        PH_IAC    = 5'b00010,
        PH_OPTION = 5'b00100,
        PH_SUB    = 5'b01000,
        PH_SUBIAC = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    verb_t       verb_reg, verb_next;
    logic [7:0]  head_reg [2];
    logic [7:0]  head_next [2];
    logic [1:0]  count_reg, count_next;
    logic        echo_reg, echo_next;

    // Store one subnegotiation body byte, keep only the first two
    function automatic void sub_store(input logic [7:0] b,
                                      input logic [1:0] cnt,
                                      inout logic [7:0] h0,
                                      inout logic [7:0] h1,
                                      output logic [1:0] cnt_out);
        cnt_out = cnt;
        if (cnt < 2'd2)
        begin
            if (cnt[0])
            begin
                h1 = b;
            end
            else
            begin
                h0 = b;
            end
            cnt_out = cnt + 2'd1;
        end
    endfunction

    // Decode one byte against the parser state
    always_comb
    begin
        phase_next   = phase_reg;
        verb_next    = verb_reg;
        head_next[0] = head_reg[0];
        head_next[1] = head_reg[1];
        count_next   = count_reg;
        echo_next    = echo_reg;
        desc_valid   = 1'b0;
        desc.kind    = KIND_DATA;
        desc.verb    = B_WONT;
        desc.data    = rx_byte;

        case (phase_reg)
            PH_IAC:
            begin
                phase_next = PH_DATA;
                case (rx_byte)
                    B_IAC:   desc_valid = 1'b1;
                    B_WILL:  begin verb_next = VERB_WILL; phase_next = PH_OPTION; end
                    B_WONT:  begin verb_next = VERB_WONT; phase_next = PH_OPTION; end
                    B_DO:    begin verb_next = VERB_DO;   phase_next = PH_OPTION; end
                    B_DONT:  begin verb_next = VERB_DONT; phase_next = PH_OPTION; end
                    B_SB:    begin count_next = 2'd0;     phase_next = PH_SUB;    end
                    default: phase_next = PH_DATA;
                endcase
            end
            PH_OPTION:
            begin
                phase_next = PH_DATA;
                desc_valid = 1'b1;
                desc.kind  = KIND_REPLY3;
                case (verb_reg)
                    VERB_WILL:
                    begin
                        if (rx_byte == TN_ECHO)
                        begin
                            desc.verb = B_DO;
                            echo_next = 1'b1;
                        end
                        else if (rx_byte == TN_SGA)
                        begin
                            desc.verb = B_DO;
                        end
                        else
                        begin
                            desc.verb = B_DONT;
                        end
                    end
                    VERB_WONT:
                    begin
                        desc.verb = B_DONT;
                        if (rx_byte == TN_ECHO)
                        begin
                            echo_next = 1'b0;
                        end
                    end
                    VERB_DO:
                    begin
                        if (rx_byte == TN_TTYPE || rx_byte == TN_SGA)
                        begin
                            desc.verb = B_WILL;
                        end
                        else if (rx_byte == TN_NAWS)
                        begin
                            desc.verb = B_WILL;
                            desc.kind = KIND_NAWS;
                        end
                        else
                        begin
                            desc.verb = B_WONT;
                        end
                    end
                    default: desc.verb = B_WONT;
                endcase
            end
            PH_SUB:
            begin
                if (rx_byte == B_IAC)
                begin
                    phase_next = PH_SUBIAC;
                end
                else
                begin
                    sub_store(rx_byte, count_reg, head_next[0], head_next[1], count_next);
                end
            end
            PH_SUBIAC:
            begin
                if (rx_byte == B_SE)
                begin
                    if (count_reg == 2'd2 && head_reg[0] == TN_TTYPE &&
                        head_reg[1] == TTYPE_SEND)
                    begin
                        desc_valid = 1'b1;
                        desc.kind  = KIND_TTYPE;
                    end
                    count_next = 2'd0;
                    phase_next = PH_DATA;
                end
                else if (rx_byte == B_IAC)
                begin
                    sub_store(B_IAC, count_reg, head_next[0], head_next[1], count_next);
                    phase_next = PH_SUB;
                end
                else
                begin
                    count_next = 2'd0;
                    phase_next = PH_DATA;
                end
            end
            default:
            begin
                if (rx_byte == B_IAC)
                begin
                    phase_next = PH_IAC;
                end
                else
                begin
                    desc_valid = 1'b1;
                    phase_next = PH_DATA;
                end
            end
        endcase

        desc.echo = echo_next;
    end

    // Advance the parser state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DATA;
            verb_reg  <= VERB_WILL;
            count_reg <= 2'd0;
            echo_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            verb_reg  <= verb_next;
            count_reg <= count_next;
            echo_reg  <= echo_next;
        end
    end

    // Subnegotiation head bytes, read only once written
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_reg[0] <= head_next[0];
            head_reg[1] <= head_next[1];
        end
    end

endmodule

`default_nettype wire

// File: design/tn_neg_emit.sv
`default_nettype none

module tn_neg_emit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load,
    input  wire tn_neg_pkg::burst_t desc,
    input  wire logic [7:0]         window_width,
    input  wire logic [7:0]         window_height,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic                    is_reply,
    output logic [7:0]              out_byte,
    output logic                    echo,
    output logic                    last,
    output logic                    can_load
);
    import tn_neg_pkg::*;

    burst_t      burst_reg;
    logic        valid_reg, valid_next;
    logic [3:0]  idx_reg, idx_next;
    logic        take;
    logic [7:0]  w_sent, h_sent;

    // Keep 0xFF out of the window-size message
    assign w_sent = (window_width == B_IAC) ? 8'hFE : window_width;
    assign h_sent = (window_height == B_IAC) ? 8'hFE : window_height;

    assign m_tvalid = valid_reg;
    assign is_reply = (burst_reg.kind != KIND_DATA);
    assign echo     = burst_reg.echo;
    assign last     = (idx_reg == burst_len(burst_reg.kind) - 4'd1);
    assign take     = valid_reg && m_tready;
    assign can_load = !valid_reg || (take && last);

    // Select the byte at the current position of the burst
    always_comb
    begin
        case (burst_reg.kind)
            KIND_DATA:
            begin
                out_byte = burst_reg.data;
            end
            KIND_REPLY3:
            begin
                case (idx_reg)
                    4'd0:    out_byte = B_IAC;
                    4'd1:    out_byte = burst_reg.verb;
                    default: out_byte = burst_reg.data;
                endcase
            end
            KIND_NAWS:
            begin
                case (idx_reg)
                    4'd0:    out_byte = B_IAC;
                    4'd1:    out_byte = B_WILL;
                    4'd2:    out_byte = TN_NAWS;
                    4'd3:    out_byte = B_IAC;
                    4'd4:    out_byte = B_SB;
                    4'd5:    out_byte = TN_NAWS;
                    4'd6:    out_byte = 8'd0;
                    4'd7:    out_byte = w_sent;
                    4'd8:    out_byte = 8'd0;
                    4'd9:    out_byte = h_sent;
                    4'd10:   out_byte = B_IAC;
                    default: out_byte = B_SE;
                endcase
            end
            default:
            begin
                out_byte = ttype_byte(idx_reg);
            end
        endcase
    end

    // Load a new burst, or step through the current one
    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (take)
        begin
            if (last)
            begin
                valid_next = 1'b0;
                idx_next   = 4'd0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 4'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Burst contents, captured on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= desc;
        end
    end

endmodule

`default_nettype wire

// File: design/telnet_option_negotiator_top.sv
// Telnet receive-side option negotiator.
// Slave stream: one received Telnet byte per transaction on s_tdata.
// Master stream: clean user bytes (m_tuser = 0) and bytes to send back to
// the peer (m_tuser = 1); m_tlast marks the final byte caused by one input
// byte, and m_tdata[8] carries the remote echo flag after that byte.
// Config channel: cfg_index 0 sets window width, 1 sets window height; it
// is always ready and should be written only while the block is idle.
// An input byte that produces output shows its first result in the cycle
// after acceptance, from the burst register.
// One input byte is taken per cycle while each causes at most one result
// and m_tready is high; a negotiation reply of 3, 11 or 12 bytes holds
// s_tready low while it is stepped out of the burst register.
// Bytes that are consumed silently cause no stall of their own.
// Reset: parser returns to the data phase, echo off, width 80, height 24,
// and no result is pending.
// When m_tready is low, the current result holds and s_tready stays low
// while it waits, so no byte is dropped.
`default_nettype none

module telnet_option_negotiator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: [7:0] rx_byte
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // m_tdata: [7:0] out_byte, [8] remote_echo_on, [15:9] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tlast,
    // m_tuser: [0] is_reply
    output logic             m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import tn_neg_pkg::*;

    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic        in_fire;
    logic        can_load;
    burst_t      desc;
    logic        desc_valid;
    logic [7:0]  out_byte;
    logic        echo;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_load;
    assign in_fire   = s_tvalid && s_tready;

    // Window size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    tn_neg_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_fire),
        .rx_byte    (s_tdata),
        .desc       (desc),
        .desc_valid (desc_valid)
    );

    tn_neg_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (in_fire && desc_valid),
        .desc          (desc),
        .window_width  (width_reg),
        .window_height (height_reg),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .is_reply      (m_tuser),
        .out_byte      (out_byte),
        .echo          (echo),
        .last          (m_tlast),
        .can_load      (can_load)
    );

    assign m_tdata = {7'd0, echo, out_byte};

endmodule

`default_nettype wire

// File: design/tn_neg_checker.sv
`default_nettype none
`include "telnet_option_negotiator_top_defines.svh"

module tn_neg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // A stalled result stays offered
    `TN_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A clean user byte is always the only result of its input byte
    `TN_ASSERT_NOW(a_data_single, m_tvalid && !m_tuser, m_tlast, "user byte not last of run")

    // Input is held off only while a result is waiting
    `TN_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with no pending result")

    // A reply burst continues with reply bytes until its last byte
    `TN_ASSERT_NEXT(a_burst_cont, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tuser,
                    "reply burst broken")

    // Padding bits of the output word stay zero
    `TN_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[15:9] == 7'd0, "nonzero padding in m_tdata")

endmodule

bind telnet_option_negotiator_top tn_neg_checker u_tn_neg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: verif/telnet_option_negotiator_top_test.sv
`timescale 1ns / 1ps

module telnet_option_negotiator_top_test;
    import tn_neg_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [39:0] TERM_NAME = "vt220";

    // Receive parser phases
    typedef enum logic [2:0] {
        PH_DATA   = 3'd0,
        PH_IAC    = 3'd1,
        PH_OPTION = 3'd2,
        PH_SUB    = 3'd3,
        PH_SUBIAC = 3'd4
    } rx_phase_t;

    // One output transaction as predicted
    typedef struct packed {
        logic       is_reply;
        logic [7:0] value;
        logic       echo;
        logic       last;
    } tn_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    // Predictor state
    rx_phase_t   parse_phase;
    verb_t       pend_verb;
    logic [7:0]  sub_bytes [2];
    int          sub_len;
    logic        echo_flag;
    logic [7:0]  win_cols;
    logic [7:0]  win_rows;

    tn_result_t  expected_q [$];
    int          error_count;
    int          cycle_count;
    int          sent_count;
    bit          stall_on;

    telnet_option_negotiator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Output backpressure
    always @(negedge clk)
    begin
        m_tready <= !(stall_on && $urandom_range(0, 99) < 30);
    end

    // Compute the results caused by one received byte and queue them
    task automatic predict_rx(input logic [7:0] b);
        logic [7:0] burst [$];
        logic       reply;
        logic [7:0] resp;
        tn_result_t r;
        reply = 1'b1;
        case (parse_phase)
            PH_IAC:
            begin
                parse_phase = PH_OPTION;
                if (b == B_IAC)
                begin
                    burst.push_back(B_IAC);
                    reply = 1'b0;
                    parse_phase = PH_DATA;
                end
                else if (b == B_WILL)
                    pend_verb = VERB_WILL;
                else if (b == B_WONT)
                    pend_verb = VERB_WONT;
                else if (b == B_DO)
                    pend_verb = VERB_DO;
                else if (b == B_DONT)
                    pend_verb = VERB_DONT;
                else if (b == B_SB)
                begin
                    sub_len = 0;
                    parse_phase = PH_SUB;
                end
                else
                    parse_phase = PH_DATA;
            end
            PH_OPTION:
            begin
                case (pend_verb)
                    VERB_WILL:
                    begin
                        resp = (b == TN_ECHO || b == TN_SGA) ? B_DO : B_DONT;
                        if (b == TN_ECHO)
                            echo_flag = 1'b1;
                    end
                    VERB_WONT:
                    begin
                        resp = B_DONT;
                        if (b == TN_ECHO)
                            echo_flag = 1'b0;
                    end
                    VERB_DO:
                        resp = (b == TN_TTYPE || b == TN_SGA || b == TN_NAWS) ? B_WILL
                                                                              : B_WONT;
                    default:
                        resp = B_WONT;
                endcase
                burst.push_back(B_IAC);
                burst.push_back(resp);
                burst.push_back(b);
                // Window size follows the agreement to NAWS; 255 is never sent
                if (pend_verb == VERB_DO && b == TN_NAWS)
                begin
                    burst.push_back(B_IAC);
                    burst.push_back(B_SB);
                    burst.push_back(TN_NAWS);
                    burst.push_back(8'd0);
                    burst.push_back(win_cols == 8'hFF ? 8'hFE : win_cols);
                    burst.push_back(8'd0);
                    burst.push_back(win_rows == 8'hFF ? 8'hFE : win_rows);
                    burst.push_back(B_IAC);
                    burst.push_back(B_SE);
                end
                parse_phase = PH_DATA;
            end
            PH_SUB:
            begin
                if (b == B_IAC)
                    parse_phase = PH_SUBIAC;
                else if (sub_len < 2)
                begin
                    sub_bytes[sub_len] = b;
                    sub_len++;
                end
            end
            PH_SUBIAC:
            begin
                if (b == B_SE)
                begin
                    // Terminal type request gets IAC SB TTYPE IS "vt220" IAC SE
                    if (sub_len == 2 && sub_bytes[0] == TN_TTYPE
                        && sub_bytes[1] == TTYPE_SEND)
                    begin
                        burst.push_back(B_IAC);
                        burst.push_back(B_SB);
                        burst.push_back(TN_TTYPE);
                        burst.push_back(8'd0);
                        for (int k = 4; k >= 0; k--)
                            burst.push_back(TERM_NAME[8*k +: 8]);
                        burst.push_back(B_IAC);
                        burst.push_back(B_SE);
                    end
                    sub_len = 0;
                    parse_phase = PH_DATA;
                end
                else if (b == B_IAC)
                begin
                    if (sub_len < 2)
                    begin
                        sub_bytes[sub_len] = B_IAC;
                        sub_len++;
                    end
                    parse_phase = PH_SUB;
                end
                else
                begin
                    sub_len = 0;
                    parse_phase = PH_DATA;
                end
            end
            default:
            begin
                if (b == B_IAC)
                    parse_phase = PH_IAC;
                else
                begin
                    burst.push_back(b);
                    reply = 1'b0;
                end
            end
        endcase
        foreach (burst[i])
        begin
            r.is_reply = reply;
            r.value    = burst[i];
            r.echo     = echo_flag;
            r.last     = (i == burst.size() - 1);
            expected_q.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare each output transaction with the oldest expectation
    always @(posedge clk)
    begin
        tn_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected output, expected none actual byte %h reply %b",
                         $time, m_tdata[7:0], m_tuser);
                error_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                check_field("out_byte", 16'(e.value), 16'(m_tdata[7:0]));
                check_field("remote_echo_on", 16'(e.echo), 16'(m_tdata[8]));
                check_field("tdata padding", 16'd0, 16'(m_tdata[15:9]));
                check_field("is_reply", 16'(e.is_reply), 16'(m_tuser));
                check_field("last_of_run", 16'(e.last), 16'(m_tlast));
            end
        end
    end

    // Drive one byte and hold it until the block takes it
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (stall_on && $urandom_range(0, 99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_rx(b);
        sent_count++;
    endtask

    // Stop sending and wait until every expected result is out
    task automatic drain_outputs();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_WIDTH)
            win_cols = val;
        else
            win_rows = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_cmd(input logic [7:0] verb, input logic [7:0] opt);
        send_byte(B_IAC);
        send_byte(verb);
        send_byte(opt);
    endtask

    // Body byte of a subnegotiation, doubling IAC
    task automatic send_sub_byte(input logic [7:0] b);
        send_byte(b);
        if (b == B_IAC)
            send_byte(B_IAC);
    endtask

    // Extremes, every verb and the parser corner cases with reset window values
    task automatic test_directed_bytes();
        send_byte(8'h00);
        send_byte(8'hFE);
        send_byte(B_IAC);
        send_byte(B_IAC);
        // unknown command after IAC is swallowed
        send_byte(B_IAC);
        send_byte(8'hF1);
        send_cmd(B_WILL, TN_ECHO);
        send_cmd(B_DO, TN_NAWS);
        send_cmd(B_WONT, TN_ECHO);
        send_cmd(B_DONT, 8'hFF);
        // long terminal type request, extra body bytes dropped
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(TN_TTYPE);
        send_byte(TTYPE_SEND);
        send_byte(8'h07);
        send_byte(B_IAC);
        send_byte(B_SE);
        // doubled IAC in the body, then an abandoned subnegotiation
        send_byte(B_IAC);
        send_byte(B_SB);
        send_sub_byte(B_IAC);
        send_byte(B_IAC);
        send_byte(8'h05);
        drain_outputs();
    endtask

    // Window registers at their extremes, including the clamped value
    task automatic test_window_regs();
        logic [7:0] cols [4] = '{8'd1, 8'd254, 8'd255, 8'd0};
        logic [7:0] rows [4] = '{8'd254, 8'd1, 8'd0, 8'd255};
        for (int i = 0; i < 4; i++)
        begin
            write_reg(CFG_WIDTH, cols[i]);
            write_reg(CFG_HEIGHT, rows[i]);
            send_cmd(B_DO, TN_NAWS);
            drain_outputs();
        end
    endtask

    task automatic send_random_sequence();
        int         pick;
        int         mode;
        logic [7:0] opt;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_byte(8'($urandom_range(0, 254)));
        else if (pick < 58)
        begin
            case ($urandom_range(0, 4))
                0:       opt = TN_ECHO;
                1:       opt = TN_SGA;
                2:       opt = TN_TTYPE;
                3:       opt = TN_NAWS;
                default: opt = 8'($urandom_range(0, 255));
            endcase
            // WILL, WONT, DO and DONT are consecutive codes
            send_cmd(B_WILL + 8'($urandom_range(0, 3)), opt);
        end
        else if (pick < 86)
        begin
            send_byte(B_IAC);
            send_byte(B_SB);
            mode = $urandom_range(0, 2);
            if (mode == 0)
            begin
                send_byte(TN_TTYPE);
                send_byte(TTYPE_SEND);
            end
            else if (mode == 1)
            begin
                send_byte(TN_TTYPE);
                send_sub_byte(8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(0, 2))
                send_sub_byte(8'($urandom_range(0, 255)));
            send_byte(B_IAC);
            // mostly a proper end, sometimes an abandon
            if ($urandom_range(0, 99) < 85)
                send_byte(B_SE);
            else
                send_byte(8'($urandom_range(0, 8'hEF)));
        end
        else if (pick < 92)
        begin
            send_byte(B_IAC);
            send_byte(B_IAC);
        end
        else
        begin
            send_byte(B_IAC);
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Random traffic in phases with different window settings and stalls
    task automatic test_random_traffic();
        int goal;
        for (int ph = 0; ph < 4; ph++)
        begin
            stall_on = (ph != 0);
            if (ph != 0)
            begin
                write_reg(CFG_WIDTH, 8'($urandom_range(1, 254)));
                write_reg(CFG_HEIGHT, 8'($urandom_range(1, 254)));
            end
            goal = sent_count + 83;
            while (sent_count < goal)
                send_random_sequence();
            drain_outputs();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_WIDTH;
        cfg_data    = 8'h00;
        stall_on    = 1'b1;
        error_count = 0;
        cycle_count = 0;
        sent_count  = 0;
        parse_phase = PH_DATA;
        pend_verb   = VERB_WILL;
        sub_bytes   = '{8'h00, 8'h00};
        sub_len     = 0;
        echo_flag   = 1'b0;
        win_cols    = WIDTH_RESET;
        win_rows    = HEIGHT_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed_bytes();
        test_window_regs();
        test_random_traffic();
        drain_outputs();
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/tn_neg_pkg.sv
design/tn_neg_parse.sv
design/tn_neg_emit.sv
design/telnet_option_negotiator_top.sv
design/tn_neg_checker.sv
verif/telnet_option_negotiator_top_test.sv
